/* sv/ltlb_pkg.sv */
// shared types and request codes for the locked translation cache
package ltlb_pkg;

  localparam logic [2:0] REQ_LOOKUP     = 3'd0;
  localparam logic [2:0] REQ_TOUCH      = 3'd1;
  localparam logic [2:0] REQ_VICTIM     = 3'd2;
  localparam logic [2:0] REQ_FILL       = 3'd3;
  localparam logic [2:0] REQ_FLUSH_ALL  = 3'd4;
  localparam logic [2:0] REQ_FLUSH_TASK = 3'd5;

  localparam logic [1:0] CFG_CURRENT_TASK = 2'd0;
  localparam logic [1:0] CFG_PAGE_SHIFT   = 2'd1;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_TOUCH,
    OP_VICTIM,
    OP_FILL,
    OP_FLUSH_ALL,
    OP_FLUSH_TASK,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WALK,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] addr;
    logic [3:0]  fc;
    logic [2:0]  tsk;
    logic        shared;
    logic        lock_req;
    logic [5:0]  slot;
    logic        slot_ok;
  } cmd_t;

endpackage

/* sv/ltlb_front.sv */
// request decode and two-deep command queue
module ltlb_front #(
  parameter int ENTRY_COUNT   = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               req_type_i,
  input  logic [31:0]              logical_address_i,
  input  logic [3:0]               function_code_i,
  input  logic [2:0]               task_tag_i,
  input  logic                     shared_flag_i,
  input  logic                     lock_request_i,
  input  logic [PAYLOAD_WIDTH-1:0] entry_payload_i,
  input  logic [5:0]               slot_i,
  output logic                     q_valid_o,
  output ltlb_pkg::cmd_t           q_cmd_o,
  output logic [PAYLOAD_WIDTH-1:0] q_pay_o,
  input  logic                     q_pop_i
);

  ltlb_pkg::cmd_t             cmd_q [2];
  logic [PAYLOAD_WIDTH-1:0]   pay_q [2];
  logic                       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       push;
  ltlb_pkg::cmd_t             cmd_new;

  always_comb begin
    cmd_new          = '0;
    cmd_new.addr     = logical_address_i;
    cmd_new.fc       = function_code_i;
    cmd_new.tsk      = task_tag_i;
    cmd_new.shared   = shared_flag_i;
    cmd_new.lock_req = lock_request_i;
    cmd_new.slot     = slot_i;
    cmd_new.slot_ok  = (32'(slot_i) < ENTRY_COUNT);
    unique case (req_type_i)
      ltlb_pkg::REQ_LOOKUP:     cmd_new.op = ltlb_pkg::OP_LOOKUP;
      ltlb_pkg::REQ_TOUCH:      cmd_new.op = ltlb_pkg::OP_TOUCH;
      ltlb_pkg::REQ_VICTIM:     cmd_new.op = ltlb_pkg::OP_VICTIM;
      ltlb_pkg::REQ_FILL:       cmd_new.op = ltlb_pkg::OP_FILL;
      ltlb_pkg::REQ_FLUSH_ALL:  cmd_new.op = ltlb_pkg::OP_FLUSH_ALL;
      ltlb_pkg::REQ_FLUSH_TASK: cmd_new.op = ltlb_pkg::OP_FLUSH_TASK;
      default:                  cmd_new.op = ltlb_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = cmd_q[rd_ptr_q];
  assign q_pay_o    = pay_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= cmd_new;
      pay_q[wr_ptr_q] <= entry_payload_i;
    end
  end

endmodule

/* sv/ltlb_back.sv */
// entry store, request execution and result register
module ltlb_back #(
  parameter int ENTRY_COUNT   = 64,
  parameter int LOCK_CEILING  = 63,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [3:0]               cfg_wdata_i,
  input  logic                     q_valid_i,
  input  ltlb_pkg::cmd_t           q_cmd_i,
  input  logic [PAYLOAD_WIDTH-1:0] q_pay_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_o,
  output logic [5:0]               slot_index_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_out_o,
  output logic                     locked_out_o,
  output logic                     shared_out_o,
  output logic                     lock_warning_o
);

  localparam int IDX_W = $clog2(ENTRY_COUNT);
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);

  ltlb_pkg::back_state_e state_q, state_d;

  logic [2:0]               cur_task_q;
  logic [3:0]               page_shift_q;
  logic [ENTRY_COUNT-1:0]   valid_q, valid_d, hist_q, hist_d, lock_q, lock_d;
  logic [ENTRY_COUNT-1:0]   shared_q;
  logic [31:0]              tag_addr_q [ENTRY_COUNT];
  logic [3:0]               tag_fc_q   [ENTRY_COUNT];
  logic [2:0]               tag_task_q [ENTRY_COUNT];
  logic [PAYLOAD_WIDTH-1:0] pay_mem    [ENTRY_COUNT];
  logic [PAYLOAD_WIDTH-1:0] rd_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic                     lk_hit_q, lk_lock_q, lk_shr_q;
  logic [IDX_W-1:0]         lk_idx_q;
  logic [IDX_W-1:0]         walk_q;
  logic [2:0]               walk_task_q;
  logic                     walk_last;

  logic [ENTRY_COUNT-1:0]   match_vec;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_idx, vic_inv, vic_free, vic_unl, victim, sidx;
  logic [31:0]              pmask;
  logic                     lk, wr_en, out_free, load;

  logic                     o_valid_q, o_hit_q, o_lock_q, o_shr_q, o_warn_q;
  logic [5:0]               o_idx_q;
  logic [PAYLOAD_WIDTH-1:0] o_pay_q;
  logic                     o_hit_d, o_lock_d, o_shr_d;
  logic [5:0]               o_idx_d;
  logic [PAYLOAD_WIDTH-1:0] o_pay_d;

  assign pmask     = 32'hFFFF_FFFF << page_shift_q;
  assign sidx      = IDX_W'(q_cmd_i.slot);
  assign out_free  = !o_valid_q || !out_stall_i;
  assign walk_last = (32'(walk_q) == ENTRY_COUNT - 1);

  // parallel tag compare over all entries
  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      match_vec[i] = valid_q[i] && (((tag_addr_q[i] ^ q_cmd_i.addr) & pmask) == 32'd0)
                     && (tag_fc_q[i] == q_cmd_i.fc)
                     && (shared_q[i] || (tag_task_q[i] == cur_task_q));
    end
  end

  // lowest-index priority encoders
  always_comb begin
    hit_idx  = '0;
    vic_inv  = '0;
    vic_free = '0;
    vic_unl  = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IDX_W'(i);
      if (!valid_q[i]) vic_inv = IDX_W'(i);
      if (!lock_q[i] && !hist_q[i]) vic_free = IDX_W'(i);
      if (!lock_q[i]) vic_unl = IDX_W'(i);
    end
  end

  assign hit_any = |match_vec;

  always_comb begin
    priority if (!(&valid_q))            victim = vic_inv;
    else if (|(~lock_q & ~hist_q))       victim = vic_free;
    else if (!(&lock_q))                 victim = vic_unl;
    else                                 victim = IDX_W'(ENTRY_COUNT - 1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ltlb_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.op == ltlb_pkg::OP_LOOKUP) state_d = ltlb_pkg::BK_READ;
          else if (q_cmd_i.op == ltlb_pkg::OP_FLUSH_TASK) state_d = ltlb_pkg::BK_WALK;
        end
      end
      ltlb_pkg::BK_READ: if (out_free) state_d = ltlb_pkg::BK_IDLE;
      ltlb_pkg::BK_WALK: if (walk_last) state_d = ltlb_pkg::BK_DONE;
      ltlb_pkg::BK_DONE: if (out_free) state_d = ltlb_pkg::BK_IDLE;
      default:           state_d = ltlb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    valid_d  = valid_q;
    hist_d   = hist_q;
    lock_d   = lock_q;
    cnt_d    = cnt_q;
    q_pop_o  = 1'b0;
    load     = 1'b0;
    wr_en    = 1'b0;
    lk       = 1'b0;
    o_hit_d  = 1'b0;
    o_idx_d  = '0;
    o_pay_d  = '0;
    o_lock_d = 1'b0;
    o_shr_d  = 1'b0;
    unique case (state_q)
      ltlb_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.op)
            ltlb_pkg::OP_LOOKUP, ltlb_pkg::OP_FLUSH_TASK: q_pop_o = 1'b1;
            default: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                load    = 1'b1;
                unique case (q_cmd_i.op)
                  ltlb_pkg::OP_TOUCH: begin
                    o_idx_d = q_cmd_i.slot;
                    if (q_cmd_i.slot_ok) hist_d[sidx] = 1'b1;
                  end
                  ltlb_pkg::OP_VICTIM: o_idx_d = 6'(victim);
                  ltlb_pkg::OP_FILL: begin
                    o_idx_d = q_cmd_i.slot;
                    if (q_cmd_i.slot_ok) begin
                      lk            = q_cmd_i.lock_req && (32'(cnt_q) < LOCK_CEILING);
                      wr_en         = 1'b1;
                      valid_d[sidx] = 1'b1;
                      hist_d[sidx]  = 1'b1;
                      lock_d[sidx]  = lk;
                      cnt_d         = cnt_q - CNT_W'(valid_q[sidx] && lock_q[sidx])
                                      + CNT_W'(lk);
                      o_lock_d      = lk;
                      // new generation once every unlocked entry has been used
                      if (!(|(~lock_d & ~hist_d))) begin
                        for (int i = 0; i < ENTRY_COUNT; i++) begin
                          if (32'(sidx) != i && !lock_d[i]) hist_d[i] = 1'b0;
                        end
                      end
                    end
                  end
                  ltlb_pkg::OP_FLUSH_ALL: begin
                    valid_d = '0;
                    hist_d  = '0;
                    lock_d  = '0;
                    cnt_d   = '0;
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
      ltlb_pkg::BK_READ: begin
        if (out_free) begin
          load     = 1'b1;
          o_hit_d  = lk_hit_q;
          o_idx_d  = lk_hit_q ? 6'(lk_idx_q) : 6'd0;
          o_pay_d  = lk_hit_q ? rd_q : '0;
          o_lock_d = lk_hit_q && lk_lock_q;
          o_shr_d  = lk_hit_q && lk_shr_q;
        end
      end
      ltlb_pkg::BK_WALK: begin
        if (valid_q[walk_q] && !shared_q[walk_q] && (tag_task_q[walk_q] == walk_task_q)) begin
          valid_d[walk_q] = 1'b0;
          hist_d[walk_q]  = 1'b0;
          lock_d[walk_q]  = 1'b0;
          if (lock_q[walk_q]) cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ltlb_pkg::BK_DONE: load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ltlb_pkg::BK_IDLE;
      cur_task_q   <= 3'd0;
      page_shift_q <= 4'd8;
      valid_q      <= '0;
      hist_q       <= '0;
      lock_q       <= '0;
      cnt_q        <= '0;
      walk_q       <= '0;
      o_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      hist_q  <= hist_d;
      lock_q  <= lock_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i && cfg_index_i == ltlb_pkg::CFG_CURRENT_TASK) cur_task_q <= cfg_wdata_i[2:0];
      if (cfg_we_i && cfg_index_i == ltlb_pkg::CFG_PAGE_SHIFT) page_shift_q <= cfg_wdata_i;
      if (state_q == ltlb_pkg::BK_WALK) walk_q <= walk_last ? '0 : walk_q + IDX_W'(1);
      if (load) o_valid_q <= 1'b1;
      else if (!out_stall_i) o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      shared_q[sidx]   <= q_cmd_i.shared;
      tag_addr_q[sidx] <= q_cmd_i.addr;
      tag_fc_q[sidx]   <= q_cmd_i.fc;
      tag_task_q[sidx] <= q_cmd_i.tsk;
      pay_mem[sidx]    <= q_pay_i;
    end
    if (state_q == ltlb_pkg::BK_IDLE && q_pop_o && q_cmd_i.op == ltlb_pkg::OP_LOOKUP) begin
      rd_q      <= pay_mem[hit_idx];
      lk_hit_q  <= hit_any;
      lk_idx_q  <= hit_idx;
      lk_lock_q <= lock_q[hit_idx];
      lk_shr_q  <= shared_q[hit_idx];
    end
    if (state_q == ltlb_pkg::BK_IDLE && q_pop_o) walk_task_q <= q_cmd_i.tsk;
    if (load) begin
      o_hit_q  <= o_hit_d;
      o_idx_q  <= o_idx_d;
      o_pay_q  <= o_pay_d;
      o_lock_q <= o_lock_d;
      o_shr_q  <= o_shr_d;
      o_warn_q <= (32'(cnt_d) >= LOCK_CEILING);
    end
  end

  assign out_valid_o    = o_valid_q;
  assign hit_o          = o_hit_q;
  assign slot_index_o   = o_idx_q;
  assign payload_out_o  = o_pay_q;
  assign locked_out_o   = o_lock_q;
  assign shared_out_o   = o_shr_q;
  assign lock_warning_o = o_warn_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= ENTRY_COUNT) else $error("locked count out of range");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop from empty queue");

  a_walk_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ltlb_pkg::BK_WALK |=> state_q == ltlb_pkg::BK_WALK
                                     || state_q == ltlb_pkg::BK_DONE)
    else $error("flush walk left early");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free) else $error("result register overwritten");

endmodule

/* sv/locked_tlb_pseudo_lru.sv */
// Fully associative translation cache with entry locking and one-bit history.
// Requests arrive on the input channel (in_valid_i / in_stall_o) and each
// request gives exactly one result transaction on the output channel
// (out_valid_o / out_stall_i). A two-deep command queue separates request
// decode from execution, so requests keep being taken while a result waits.
// A lookup pops the queue with tag compare and payload memory read, then
// loads the result register; touch, victim query, fill, flush all and unknown
// requests load it as they are popped; flush by task walks the entries one
// per cycle, then loads it. The execution unit takes no request while a lookup
// or flush by task is in progress. Configuration (current task, page shift) is
// written through cfg_we_i, cfg_index_i and cfg_wdata_i while the cache is
// idle; this binds the user, the block itself does not enforce it. Reset
// clears all valid, lock and history bits and the locked-entry count; no
// clearing pass is needed. When the receiver stalls, the result is held and
// no new result is loaded while the result register is occupied.
module locked_tlb_pseudo_lru #(
  parameter int ENTRY_COUNT   = 64,
  parameter int LOCK_CEILING  = 63,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [3:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               req_type_i,
  input  logic [31:0]              logical_address_i,
  input  logic [3:0]               function_code_i,
  input  logic [2:0]               task_tag_i,
  input  logic                     shared_flag_i,
  input  logic                     lock_request_i,
  input  logic [PAYLOAD_WIDTH-1:0] entry_payload_i,
  input  logic [5:0]               slot_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_o,
  output logic [5:0]               slot_index_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_out_o,
  output logic                     locked_out_o,
  output logic                     shared_out_o,
  output logic                     lock_warning_o
);

  logic                     q_valid, q_pop;
  ltlb_pkg::cmd_t           q_cmd;
  logic [PAYLOAD_WIDTH-1:0] q_pay;

  ltlb_front #(
    .ENTRY_COUNT  (ENTRY_COUNT),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .logical_address_i(logical_address_i),
    .function_code_i  (function_code_i),
    .task_tag_i       (task_tag_i),
    .shared_flag_i    (shared_flag_i),
    .lock_request_i   (lock_request_i),
    .entry_payload_i  (entry_payload_i),
    .slot_i           (slot_i),
    .q_valid_o        (q_valid),
    .q_cmd_o          (q_cmd),
    .q_pay_o          (q_pay),
    .q_pop_i          (q_pop)
  );

  ltlb_back #(
    .ENTRY_COUNT  (ENTRY_COUNT),
    .LOCK_CEILING (LOCK_CEILING),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pay_i       (q_pay),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .slot_index_o  (slot_index_o),
    .payload_out_o (payload_out_o),
    .locked_out_o  (locked_out_o),
    .shared_out_o  (shared_out_o),
    .lock_warning_o(lock_warning_o)
  );

endmodule
